// File: rtl/core/msw_pkg.sv
// msw_pkg: shared types and constants of the motor stall window detector
// holds the status codes, the register map and the reset values of the registers
// depends on nothing
package msw_pkg;

    // result codes
    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_STALL   = 2'd1,
        ST_TIMEOUT = 2'd2
    } status_t;

    // register map, index of each register (byte address is four times this)
    localparam logic [2:0] REG_HIGH_EN    = 3'd0;
    localparam logic [2:0] REG_HIGH_LEVEL = 3'd1;
    localparam logic [2:0] REG_HIGH_NEED  = 3'd2;
    localparam logic [2:0] REG_ZERO_NEED  = 3'd3;
    localparam logic [2:0] REG_TIMEOUT    = 3'd4;
    localparam logic [2:0] REG_START      = 3'd5;

    // field widths
    localparam int unsigned SAMPLE_W = 16;
    localparam int unsigned TIME_W   = 32;
    localparam int unsigned SEEN_W   = 5;
    localparam int unsigned ADDR_W   = 5;
    localparam int unsigned DATA_W   = 32;

    // register reset values
    localparam logic                RST_HIGH_EN    = 1'b0;
    localparam logic [SAMPLE_W-1:0] RST_HIGH_LEVEL = 16'd200;
    localparam logic [SEEN_W-1:0]   RST_HIGH_NEED  = 5'd3;
    localparam logic [SEEN_W-1:0]   RST_ZERO_NEED  = 5'd15;
    localparam logic [TIME_W-1:0]   RST_TIMEOUT    = 32'd5000;
    localparam logic [TIME_W-1:0]   RST_START      = 32'd0;

    // per-beat control from the top level to each flag window
    typedef struct packed {
        logic shift;
        logic full;
    } win_ctrl_t;

    // one result beat
    typedef struct packed {
        status_t             status;
        logic [SEEN_W-1:0]   high_seen;
        logic [SEEN_W-1:0]   zero_seen;
    } out_beat_t;

endpackage

// File: rtl/core/msw_cell.sv
// msw_cell: one stage of a flag window, holding the flag of one sample
// hands its flag to the next stage on every accepted beat
// depends on nothing
module msw_cell (
    input  logic clk,
    input  logic shift,
    input  logic d,
    output logic q
);

    logic flag_reg;

    // flag storage, loaded from the neighbour on each shift
    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            flag_reg <= d;
        end
    end

    assign q = flag_reg;

endmodule

// File: rtl/core/msw_window.sv
// msw_window: sliding window of flags built as a row of msw_cell stages,
// with a running count of set flags
// depends on msw_pkg and msw_cell
module msw_window #(
    parameter int unsigned WINDOW = 20,
    parameter int unsigned CNT_W  = 5
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  msw_pkg::win_ctrl_t   ctrl,
    input  logic                 flag_in,
    output logic [CNT_W-1:0]     tally_next,
    output logic [CNT_W-1:0]     tally
);

    logic [WINDOW-1:0] tap;
    logic [CNT_W-1:0]  tally_reg;
    logic              oldest;

    // row of cells, newest flag enters at stage zero
    genvar gi;
    generate
        for (gi = 0; gi < WINDOW; gi++)
        begin : g_cell
            if (gi == 0)
            begin : g_head
                msw_cell u_cell (
                    .clk   (clk),
                    .shift (ctrl.shift),
                    .d     (flag_in),
                    .q     (tap[gi])
                );
            end
            else
            begin : g_body
                msw_cell u_cell (
                    .clk   (clk),
                    .shift (ctrl.shift),
                    .d     (tap[gi-1]),
                    .q     (tap[gi])
                );
            end
        end
    endgenerate

    // flag that drops out of a full window
    assign oldest = ctrl.full & tap[WINDOW-1];

    // running count, one up or one down per beat
    always_comb
    begin
        tally_next = tally_reg;
        if (flag_in && !oldest)
        begin
            tally_next = tally_reg + CNT_W'(1);
        end
        else if (!flag_in && oldest)
        begin
            tally_next = tally_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tally_reg <= '0;
        end
        else if (ctrl.shift)
        begin
            tally_reg <= tally_next;
        end
    end

    assign tally = tally_reg;

endmodule

// File: rtl/core/motor_stall_window_detector_unit.sv
// motor_stall_window_detector_unit: m-of-n stall detector over two flag windows
// a result beat is registered in the output register, or in the skid entry while the output stalls
// throughput: one sample per cycle while the skid entry is empty, set by the one-step count update in each window
// a two-entry output stage keeps taking samples while one result waits
// reset: counts, fill level and valids clear and registers take their reset values at once; window cells need no clear
// depends on msw_pkg, msw_window and msw_cell
module motor_stall_window_detector_unit #(
    parameter int unsigned WINDOW = 20
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // sample channel
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [msw_pkg::TIME_W-1:0]        now_ms,
    input  logic [msw_pkg::SAMPLE_W-1:0]      sample,
    // result channel
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [1:0]                        status,
    output logic [msw_pkg::SEEN_W-1:0]        high_seen,
    output logic [msw_pkg::SEEN_W-1:0]        zero_seen,
    // register port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [msw_pkg::ADDR_W-1:0]        paddr,
    input  logic [msw_pkg::DATA_W-1:0]        pwdata,
    output logic [msw_pkg::DATA_W-1:0]        prdata,
    output logic                              pready
);

    localparam int unsigned CNT_W = $clog2(WINDOW + 1);
    localparam int unsigned CMP_W = (CNT_W > msw_pkg::SEEN_W) ? CNT_W : msw_pkg::SEEN_W;

    // registers
    logic                           high_en_reg;
    logic [msw_pkg::SAMPLE_W-1:0]   high_level_reg;
    logic [msw_pkg::SEEN_W-1:0]     high_need_reg;
    logic [msw_pkg::SEEN_W-1:0]     zero_need_reg;
    logic [msw_pkg::TIME_W-1:0]     timeout_reg;
    logic [msw_pkg::TIME_W-1:0]     start_reg;

    logic                           cfg_wr;
    logic [2:0]                     cfg_idx;

    // window control
    logic [CNT_W-1:0]               fill_reg;
    logic                           in_accept;
    logic                           out_take;
    msw_pkg::win_ctrl_t             win_ctrl;
    logic                           high_flag;
    logic                           zero_flag;
    logic [CNT_W-1:0]               high_tally_next;
    logic [CNT_W-1:0]               zero_tally_next;
    logic [CNT_W-1:0]               high_tally;
    logic [CNT_W-1:0]               zero_tally;

    // checks
    logic [CMP_W-1:0]               high_cnt_ext;
    logic [CMP_W-1:0]               zero_cnt_ext;
    logic [msw_pkg::TIME_W-1:0]     elapsed;
    msw_pkg::out_beat_t             beat_next;

    // output stage
    logic                           out_valid_reg;
    msw_pkg::out_beat_t             out_beat_reg;
    logic                           skid_valid_reg;
    msw_pkg::out_beat_t             skid_beat_reg;

    // register writes
    assign cfg_wr  = psel & penable & pwrite & pready;
    assign cfg_idx = paddr[4:2];
    assign pready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            high_en_reg    <= msw_pkg::RST_HIGH_EN;
            high_level_reg <= msw_pkg::RST_HIGH_LEVEL;
            high_need_reg  <= msw_pkg::RST_HIGH_NEED;
            zero_need_reg  <= msw_pkg::RST_ZERO_NEED;
            timeout_reg    <= msw_pkg::RST_TIMEOUT;
            start_reg      <= msw_pkg::RST_START;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                msw_pkg::REG_HIGH_EN:    high_en_reg    <= pwdata[0];
                msw_pkg::REG_HIGH_LEVEL: high_level_reg <= pwdata[msw_pkg::SAMPLE_W-1:0];
                msw_pkg::REG_HIGH_NEED:  high_need_reg  <= pwdata[msw_pkg::SEEN_W-1:0];
                msw_pkg::REG_ZERO_NEED:  zero_need_reg  <= pwdata[msw_pkg::SEEN_W-1:0];
                msw_pkg::REG_TIMEOUT:    timeout_reg    <= pwdata;
                msw_pkg::REG_START:      start_reg      <= pwdata;
                default:                 ;
            endcase
        end
    end

    // register reads
    always_comb
    begin
        case (cfg_idx)
            msw_pkg::REG_HIGH_EN:    prdata = {31'd0, high_en_reg};
            msw_pkg::REG_HIGH_LEVEL: prdata = {16'd0, high_level_reg};
            msw_pkg::REG_HIGH_NEED:  prdata = {27'd0, high_need_reg};
            msw_pkg::REG_ZERO_NEED:  prdata = {27'd0, zero_need_reg};
            msw_pkg::REG_TIMEOUT:    prdata = timeout_reg;
            msw_pkg::REG_START:      prdata = start_reg;
            default:                 prdata = '0;
        endcase
    end

    // handshakes
    assign in_ready  = ~skid_valid_reg;
    assign in_accept = in_valid & in_ready;
    assign out_take  = ~out_valid_reg | out_ready;

    // fill level, saturates once the window is full
    assign win_ctrl.shift = in_accept;
    assign win_ctrl.full  = (fill_reg == CNT_W'(WINDOW));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
        end
        else if (in_accept && !win_ctrl.full)
        begin
            fill_reg <= fill_reg + CNT_W'(1);
        end
    end

    // sample flags
    assign high_flag = (sample >= high_level_reg);
    assign zero_flag = (sample == '0);

    msw_window #(
        .WINDOW (WINDOW),
        .CNT_W  (CNT_W)
    ) u_high_win (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (win_ctrl),
        .flag_in    (high_flag),
        .tally_next (high_tally_next),
        .tally      (high_tally)
    );

    msw_window #(
        .WINDOW (WINDOW),
        .CNT_W  (CNT_W)
    ) u_zero_win (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (win_ctrl),
        .flag_in    (zero_flag),
        .tally_next (zero_tally_next),
        .tally      (zero_tally)
    );

    // stall and timeout checks in priority order
    assign high_cnt_ext = CMP_W'(high_tally_next);
    assign zero_cnt_ext = CMP_W'(zero_tally_next);
    assign elapsed      = now_ms - start_reg;

    always_comb
    begin
        beat_next.high_seen = high_cnt_ext[msw_pkg::SEEN_W-1:0];
        beat_next.zero_seen = zero_cnt_ext[msw_pkg::SEEN_W-1:0];
        if (high_en_reg && (high_cnt_ext >= CMP_W'(high_need_reg)))
        begin
            beat_next.status = msw_pkg::ST_STALL;
        end
        else if (zero_cnt_ext >= CMP_W'(zero_need_reg))
        begin
            beat_next.status = msw_pkg::ST_STALL;
        end
        else if ((now_ms >= start_reg) && (elapsed >= timeout_reg))
        begin
            beat_next.status = msw_pkg::ST_TIMEOUT;
        end
        else
        begin
            beat_next.status = msw_pkg::ST_OK;
        end
    end

    // output register and skid entry, valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_take)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= in_accept;
            end
        end
        else if (in_accept)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    // output register and skid entry, payload
    always_ff @(posedge clk)
    begin
        if (out_take)
        begin
            if (skid_valid_reg)
            begin
                out_beat_reg <= skid_beat_reg;
            end
            else if (in_accept)
            begin
                out_beat_reg <= beat_next;
            end
        end
        else if (in_accept)
        begin
            skid_beat_reg <= beat_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign status    = out_beat_reg.status;
    assign high_seen = out_beat_reg.high_seen;
    assign zero_seen = out_beat_reg.zero_seen;

    // skid entry only ever holds a beat behind a waiting result
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry full while output register empty");

    // a beat taken while the result is stalled lands in the skid entry
    a_stall_to_skid: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && out_valid_reg && !out_ready) |=> skid_valid_reg)
        else $error("beat accepted under stall was not held");

    // counts never exceed the samples held in the window
    a_tally_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (high_tally <= fill_reg) && (zero_tally <= fill_reg))
        else $error("window count above fill level");

    // fill level saturates at the window length
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CNT_W'(WINDOW))
        else $error("fill level beyond window length");

endmodule

// File: sim/msw_checker.sv
`timescale 1ns / 100ps
// msw_checker: watches the sample, result and register channels of the stall detector
// keeps its own copy of both flag windows and the registers, predicts each result beat
// and compares it with the block's output; depends on msw_pkg
module msw_checker #(
    parameter int unsigned WINDOW = 20
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  logic                         in_ready,
    input  logic [msw_pkg::TIME_W-1:0]   now_ms,
    input  logic [msw_pkg::SAMPLE_W-1:0] sample,
    input  logic                         out_valid,
    input  logic                         out_ready,
    input  logic [1:0]                   status,
    input  logic [msw_pkg::SEEN_W-1:0]   high_seen,
    input  logic [msw_pkg::SEEN_W-1:0]   zero_seen,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [msw_pkg::ADDR_W-1:0]   paddr,
    input  logic [msw_pkg::DATA_W-1:0]   pwdata,
    input  logic                         pready,
    output int unsigned                  mismatches,
    output int unsigned                  outstanding
);

    // mirrored registers
    logic                         cfg_high_en;
    logic [msw_pkg::SAMPLE_W-1:0] cfg_high_level;
    logic [msw_pkg::SEEN_W-1:0]   cfg_high_need;
    logic [msw_pkg::SEEN_W-1:0]   cfg_zero_need;
    logic [msw_pkg::TIME_W-1:0]   cfg_timeout;
    logic [msw_pkg::TIME_W-1:0]   cfg_start;

    // mirrored window state
    bit          high_flags [WINDOW];
    bit          zero_flags [WINDOW];
    int unsigned fill_level;
    int unsigned oldest_slot;
    int unsigned high_tally;
    int unsigned zero_tally;

    msw_pkg::out_beat_t expected_beats [$];
    int unsigned        error_total;

    // push one sample into both windows and work out the result beat it causes
    task automatic advance_windows(input logic [msw_pkg::TIME_W-1:0] t,
                                   input logic [msw_pkg::SAMPLE_W-1:0] s,
                                   output msw_pkg::out_beat_t res);
        bit          is_high;
        bit          is_zero;
        int unsigned slot;
        is_high = (s >= cfg_high_level);
        is_zero = (s == '0);
        if (fill_level >= WINDOW)
        begin
            // full: replace the oldest flag and adjust the counts
            slot = oldest_slot;
            oldest_slot = (slot + 1 >= WINDOW) ? 0 : slot + 1;
            high_tally = high_tally - high_flags[slot] + is_high;
            zero_tally = zero_tally - zero_flags[slot] + is_zero;
        end
        else
        begin
            slot = fill_level;
            fill_level++;
            high_tally = high_tally + is_high;
            zero_tally = zero_tally + is_zero;
        end
        high_flags[slot] = is_high;
        zero_flags[slot] = is_zero;

        // first failing check wins: high current, zero current, timeout
        if (cfg_high_en && high_tally >= cfg_high_need)
            res.status = msw_pkg::ST_STALL;
        else if (zero_tally >= cfg_zero_need)
            res.status = msw_pkg::ST_STALL;
        else if (t >= cfg_start && (t - cfg_start) >= cfg_timeout)
            res.status = msw_pkg::ST_TIMEOUT;
        else
            res.status = msw_pkg::ST_OK;
        res.high_seen = high_tally[msw_pkg::SEEN_W-1:0];
        res.zero_seen = zero_tally[msw_pkg::SEEN_W-1:0];
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        msw_pkg::out_beat_t want;
        if (!rst_n)
        begin
            cfg_high_en    = msw_pkg::RST_HIGH_EN;
            cfg_high_level = msw_pkg::RST_HIGH_LEVEL;
            cfg_high_need  = msw_pkg::RST_HIGH_NEED;
            cfg_zero_need  = msw_pkg::RST_ZERO_NEED;
            cfg_timeout    = msw_pkg::RST_TIMEOUT;
            cfg_start      = msw_pkg::RST_START;
            foreach (high_flags[i]) high_flags[i] = 1'b0;
            foreach (zero_flags[i]) zero_flags[i] = 1'b0;
            fill_level  = 0;
            oldest_slot = 0;
            high_tally  = 0;
            zero_tally  = 0;
            error_total = 0;
            expected_beats.delete();
            mismatches  <= 0;
            outstanding <= 0;
        end
        else
        begin
            // result beats against the oldest prediction
            if (out_valid && out_ready)
            begin
                if (expected_beats.size() == 0)
                begin
                    error_total++;
                    if (error_total <= 10)
                        $display("result beat with nothing expected: %s %0d %0d %0d",
                                 "status/high/zero", status, high_seen, zero_seen);
                end
                else
                begin
                    want = expected_beats.pop_front();
                    if (status !== want.status || high_seen !== want.high_seen ||
                        zero_seen !== want.zero_seen)
                    begin
                        error_total++;
                        if (error_total <= 10)
                            $display({"result mismatch: expected status %0d high %0d ",
                                      "zero %0d, got status %0d high %0d zero %0d"},
                                     want.status, want.high_seen, want.zero_seen,
                                     status, high_seen, zero_seen);
                    end
                end
            end

            // sample beats, judged with the registers in force before this edge
            if (in_valid && in_ready)
            begin
                advance_windows(now_ms, sample, want);
                expected_beats.push_back(want);
            end

            // register writes
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[msw_pkg::ADDR_W-1:2])
                    msw_pkg::REG_HIGH_EN:    cfg_high_en    = pwdata[0];
                    msw_pkg::REG_HIGH_LEVEL: cfg_high_level = pwdata[msw_pkg::SAMPLE_W-1:0];
                    msw_pkg::REG_HIGH_NEED:  cfg_high_need  = pwdata[msw_pkg::SEEN_W-1:0];
                    msw_pkg::REG_ZERO_NEED:  cfg_zero_need  = pwdata[msw_pkg::SEEN_W-1:0];
                    msw_pkg::REG_TIMEOUT:    cfg_timeout    = pwdata;
                    msw_pkg::REG_START:      cfg_start      = pwdata;
                    default: ;
                endcase
            end

            mismatches  <= error_total;
            outstanding <= expected_beats.size();
        end
    end

endmodule

// File: sim/tb_motor_stall_window_detector_unit.sv
`timescale 1ns / 100ps
// tb_motor_stall_window_detector_unit: stimulus and verdict for the stall detector
// drives samples, register writes and result back-pressure; checking is done in msw_checker
// depends on msw_pkg, msw_checker and the block itself
module tb_motor_stall_window_detector_unit;

    localparam int unsigned PHASES          = 8;
    localparam int unsigned ITEMS_PER_PHASE = 230;
    localparam int unsigned DRAIN_CYCLES    = 4;
    localparam int unsigned CYCLE_LIMIT     = 1_000_000;

    typedef enum int unsigned {CUR_ZERO, CUR_HIGH, CUR_LOW, CUR_ANY} current_kind_t;
    typedef enum int unsigned {RDY_ON, RDY_OFF, RDY_COIN, RDY_THIRD} ready_mode_t;

    logic                         clk       = 1'b0;
    logic                         rst_n     = 1'b0;
    logic                         in_valid  = 1'b0;
    logic                         in_ready;
    logic [msw_pkg::TIME_W-1:0]   now_ms    = '0;
    logic [msw_pkg::SAMPLE_W-1:0] sample    = '0;
    logic                         out_valid;
    logic                         out_ready = 1'b0;
    logic [1:0]                   status;
    logic [msw_pkg::SEEN_W-1:0]   high_seen;
    logic [msw_pkg::SEEN_W-1:0]   zero_seen;
    logic                         psel      = 1'b0;
    logic                         penable   = 1'b0;
    logic                         pwrite    = 1'b0;
    logic [msw_pkg::ADDR_W-1:0]   paddr     = '0;
    logic [msw_pkg::DATA_W-1:0]   pwdata    = '0;
    logic [msw_pkg::DATA_W-1:0]   prdata;
    logic                         pready;

    int unsigned mismatches;
    int unsigned outstanding;
    int unsigned cycle_count = 0;

    // stimulus-side copy of the registers that shape samples and timestamps
    logic [msw_pkg::SAMPLE_W-1:0] cfg_level   = msw_pkg::RST_HIGH_LEVEL;
    logic [msw_pkg::TIME_W-1:0]   cfg_timeout = msw_pkg::RST_TIMEOUT;
    logic [msw_pkg::TIME_W-1:0]   cfg_start   = msw_pkg::RST_START;

    motor_stall_window_detector_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .now_ms    (now_ms),
        .sample    (sample),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .high_seen (high_seen),
        .zero_seen (zero_seen),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    msw_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .now_ms      (now_ms),
        .sample      (sample),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .status      (status),
        .high_seen   (high_seen),
        .zero_seen   (zero_seen),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .pready      (pready),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    // 4 ns clock
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb_motor_stall_window_detector_unit failed");
            $finish;
        end
    end

    // result back-pressure in segments of random mode and length
    ready_mode_t ready_mode = RDY_ON;
    int unsigned ready_left = 0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready  <= 1'b0;
            ready_mode <= RDY_ON;
            ready_left <= 0;
        end
        else
        begin
            if (ready_left == 0)
            begin
                ready_mode <= ready_mode_t'($urandom_range(0, 3));
                ready_left <= $urandom_range(1, 40);
            end
            else
                ready_left <= ready_left - 1;
            case (ready_mode)
                RDY_ON:    out_ready <= 1'b1;
                RDY_OFF:   out_ready <= 1'b0;
                RDY_COIN:  out_ready <= 1'($urandom_range(0, 1));
                default:   out_ready <= (ready_left % 3 == 0);
            endcase
        end
    end

    // one sample beat, held until taken
    task automatic send_item(input logic [msw_pkg::TIME_W-1:0] t,
                             input logic [msw_pkg::SAMPLE_W-1:0] s);
        in_valid <= 1'b1;
        now_ms   <= t;
        sample   <= s;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    // stop sending and wait for every outstanding result beat
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // setup then access cycle; psel stays up across back-to-back writes
    task automatic write_reg(input logic [2:0] idx, input logic [msw_pkg::DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
    endtask

    task automatic apply_config(input logic en, input logic [msw_pkg::SAMPLE_W-1:0] level,
                                input logic [msw_pkg::SEEN_W-1:0] high_need,
                                input logic [msw_pkg::SEEN_W-1:0] zero_need,
                                input logic [msw_pkg::TIME_W-1:0] tmo,
                                input logic [msw_pkg::TIME_W-1:0] st);
        write_reg(msw_pkg::REG_HIGH_EN,    msw_pkg::DATA_W'(en));
        write_reg(msw_pkg::REG_HIGH_LEVEL, msw_pkg::DATA_W'(level));
        write_reg(msw_pkg::REG_HIGH_NEED,  msw_pkg::DATA_W'(high_need));
        write_reg(msw_pkg::REG_ZERO_NEED,  msw_pkg::DATA_W'(zero_need));
        write_reg(msw_pkg::REG_TIMEOUT,    tmo);
        write_reg(msw_pkg::REG_START,      st);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        cfg_level   = level;
        cfg_timeout = tmo;
        cfg_start   = st;
        @(posedge clk);
    endtask

    initial
    begin : stimulus
        int unsigned                  phase;
        int unsigned                  n;
        int unsigned                  r;
        int unsigned                  burst_left;
        int unsigned                  run_left;
        int unsigned                  zero_w;
        int unsigned                  high_w;
        current_kind_t                run_kind;
        logic [msw_pkg::SAMPLE_W-1:0] lvl;
        logic [msw_pkg::TIME_W-1:0]   t;
        logic [msw_pkg::SAMPLE_W-1:0] s;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: field extremes, timeout edge, high window tracked while disabled
        send_item(32'd0, 16'd0);
        send_item(32'hFFFF_FFFF, 16'hFFFF);
        send_item(32'd4999, 16'd199);
        send_item(32'd5000, 16'd200);
        send_item(32'd5001, 16'd1);
        send_item(32'd100, 16'd300);
        wait_drained();

        // zero timeout, time before start, zero threshold above the window
        apply_config(1'b0, 16'hFFFF, 5'd0, 5'd31, 32'd0, 32'hFFFF_FFFF);
        send_item(32'hFFFF_FFFE, 16'd5);
        send_item(32'hFFFF_FFFF, 16'hFFFF);
        send_item(32'd0, 16'd0);
        wait_drained();

        // zero threshold of zero always stalls
        apply_config(1'b1, 16'd1, 5'd20, 5'd0, 32'hFFFF_FFFF, 32'd0);
        send_item(32'd0, 16'hFFFF);
        send_item(32'hFFFF_FFFF, 16'd0);
        wait_drained();

        // enabled high check with threshold zero
        apply_config(1'b1, 16'hFFFF, 5'd0, 5'd20, 32'd10, 32'd5);
        send_item(32'd1234, 16'd1);
        wait_drained();

        // random phases, each with its own settings and current mix
        burst_left = 1;
        run_left   = 0;
        run_kind   = CUR_ANY;
        for (phase = 0; phase < PHASES; phase++)
        begin
            if (phase == 0)
                apply_config(1'b1, 16'hFFFF, 5'd31, 5'd31, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
            else if (phase == 1)
                apply_config(1'b0, 16'd0, 5'd0, 5'd0, 32'd0, 32'd0);
            else
            begin
                r = $urandom_range(0, 3);
                lvl = (r == 0) ? 16'd0 : (r == 1) ? 16'hFFFF :
                      (r == 2) ? msw_pkg::SAMPLE_W'($urandom_range(1, 400)) :
                      msw_pkg::SAMPLE_W'($urandom);
                r = $urandom_range(0, 2);
                t = (r == 0) ? 32'd0 : (r == 1) ? 32'hFFFF_FFFF : $urandom_range(0, 3000);
                apply_config(1'($urandom_range(0, 1)), lvl,
                             ($urandom_range(0, 7) == 0) ? 5'(31) : 5'($urandom_range(0, 21)),
                             ($urandom_range(0, 7) == 0) ? 5'(31) : 5'($urandom_range(0, 21)),
                             t, ($urandom_range(0, 1) == 0) ? $urandom : $urandom_range(0, 5000));
            end
            zero_w = $urandom_range(5, 45);
            high_w = $urandom_range(5, 45);

            for (n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                // current samples come in runs of one kind so the counts climb and fall
                if (run_left == 0)
                begin
                    r = $urandom_range(0, 99);
                    run_kind = (r < zero_w) ? CUR_ZERO : (r < zero_w + high_w) ? CUR_HIGH :
                               (r < 92) ? CUR_LOW : CUR_ANY;
                    run_left = $urandom_range(1, 25);
                end
                run_left--;
                case (run_kind)
                    CUR_ZERO: s = '0;
                    CUR_HIGH: s = (cfg_level == 0) ? msw_pkg::SAMPLE_W'($urandom) :
                                  msw_pkg::SAMPLE_W'($urandom_range(cfg_level, 16'hFFFF));
                    CUR_LOW:  s = (cfg_level > 1) ?
                                  msw_pkg::SAMPLE_W'($urandom_range(1, cfg_level - 1)) :
                                  msw_pkg::SAMPLE_W'($urandom);
                    default:  s = msw_pkg::SAMPLE_W'($urandom);
                endcase

                // timestamps cluster around the start time and the timeout edge
                r = $urandom_range(0, 9);
                if (r < 2)
                    t = cfg_start - $urandom_range(1, 50);
                else if (r < 5)
                    t = cfg_start + cfg_timeout + $urandom_range(0, 2) - 1;
                else if (r < 8)
                    t = cfg_start + $urandom_range(0, cfg_timeout);
                else
                    t = $urandom;

                send_item(t, s);

                // bursts with random gaps, and now and then a full drain
                burst_left--;
                if ($urandom_range(0, 149) == 0)
                    wait_drained();
                else if (burst_left == 0)
                begin
                    in_valid <= 1'b0;
                    repeat ($urandom_range(1, 8)) @(posedge clk);
                end
                if (burst_left == 0)
                    burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120) :
                                 $urandom_range(1, 16);
            end
            wait_drained();
        end

        if (mismatches == 0)
            $display("tb_motor_stall_window_detector_unit passed");
        else
            $display("tb_motor_stall_window_detector_unit failed");
        $finish;
    end

endmodule

// File: sim.f
rtl/core/msw_pkg.sv
rtl/core/msw_cell.sv
rtl/core/msw_window.sv
rtl/core/motor_stall_window_detector_unit.sv
sim/msw_checker.sv
sim/tb_motor_stall_window_detector_unit.sv
